>>> rtl/bfb_pkg.sv
// Shared types and constants for the bit-file to bin converter.
// Holds the magic header table, result codes and the front-to-back queue entry.
// No dependencies.
`default_nettype none

package bfb_pkg;

	// Length of the fixed magic header at the start of the file.
	localparam int unsigned MAGIC_LEN = 13;

	// Section key that introduces the payload size.
	localparam logic [7:0] PAYLOAD_KEY = 8'h65;

	// Default depth of the queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Result codes carried in the kind field.
	typedef enum logic [1:0] {
		KIND_WORD      = 2'd0,
		KIND_BAD_MAGIC = 2'd1,
		KIND_MISMATCH  = 2'd2,
		KIND_TRUNCATED = 2'd3
	} kind_t;

	// One entry of the queue: either a finished result without payload
	// (error or empty payload) or one payload byte for the word packer.
	typedef struct packed {
		logic       is_result;  // entry is a result of its own, no byte
		kind_t      kind;       // result code when is_result is set
		logic [7:0] data;       // payload byte
		logic [2:0] count;      // bytes in the word including this one
		logic       emit;       // this byte closes a word or the file
		logic       last;       // the result is the final one
	} op_t;

	// Expected header byte at a given position; positions past the header
	// report no match so that any byte there is rejected.
	function automatic logic magic_match(input logic [3:0] idx, input logic [7:0] b);
		logic [7:0] exp;
		logic       ok;
		ok = 1'b1;
		case (idx)
			4'd0:    exp = 8'h00;
			4'd1:    exp = 8'h09;
			4'd2:    exp = 8'h0F;
			4'd3:    exp = 8'hF0;
			4'd4:    exp = 8'h0F;
			4'd5:    exp = 8'hF0;
			4'd6:    exp = 8'h0F;
			4'd7:    exp = 8'hF0;
			4'd8:    exp = 8'h0F;
			4'd9:    exp = 8'hF0;
			4'd10:   exp = 8'h00;
			4'd11:   exp = 8'h00;
			4'd12:   exp = 8'h01;
			default: begin
				exp = 8'h00;
				ok  = 1'b0;
			end
		endcase
		return ok && (b == exp);
	endfunction

endpackage

`default_nettype wire

>>> rtl/bfb_in_if.sv
// Byte stream channel into the converter: valid/ready with one file byte per beat.
// No dependencies.
`default_nettype none

interface bfb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       file_last;

	modport source (output valid, output data_byte, output file_last, input ready);
	modport sink   (input valid, input data_byte, input file_last, output ready);
endinterface

`default_nettype wire

>>> rtl/bfb_out_if.sv
// Result channel out of the converter: valid/ready with one result per beat.
// No dependencies.
`default_nettype none

interface bfb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] word;
	logic [2:0]  bytes_valid;
	logic        last;

	modport source (output valid, output kind, output word, output bytes_valid,
		output last, input ready);
	modport sink   (input valid, input kind, input word, input bytes_valid,
		input last, output ready);
endinterface

`default_nettype wire

>>> rtl/bfb_front.sv
// Front end of the converter: accepts file bytes, walks the header and sections,
// and pushes results or payload bytes into the queue. Depends on bfb_pkg, bfb_in_if.
`default_nettype none

module bfb_front (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bfb_in_if.sink      stream,
	input  wire logic   q_full,
	output logic        push,
	output bfb_pkg::op_t push_op
);

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_KEY,
		PH_ZERO,
		PH_LEN,
		PH_DATA,
		PH_SIZE,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  hidx_q, hidx_n;
	logic [7:0]  sec_q, sec_n;
	logic [23:0] size_q, size_n;
	logic [22:0] rem_q, rem_n;
	logic [1:0]  biw_q, biw_n;

	logic        beat;
	logic        push_v;
	logic        trunc_chk;
	logic [7:0]  b;
	logic        fl;
	logic [24:0] size_sum;
	logic [2:0]  count;
	logic [7:0]  sec_dec;

	// A byte is taken whenever the queue has room, also after the file has finished.
	assign stream.ready = !q_full;
	assign beat         = stream.valid && stream.ready;
	assign b            = stream.data_byte;
	assign fl           = stream.file_last;
	assign push         = beat && push_v;

	// Parser next state and queue entry for the current byte.
	always_comb begin
		phase_n   = phase_q;
		hidx_n    = hidx_q;
		sec_n     = sec_q;
		size_n    = size_q;
		rem_n     = rem_q;
		biw_n     = biw_q;
		push_v    = 1'b0;
		trunc_chk = 1'b0;
		push_op   = '0;
		size_sum  = '0;
		count     = {1'b0, biw_q} + 3'd1;
		sec_dec   = sec_q - 8'd1;

		case (phase_q)
			PH_MAGIC: begin
				if (!bfb_pkg::magic_match(hidx_q, b)) begin
					push_v            = 1'b1;
					push_op.is_result = 1'b1;
					push_op.kind      = bfb_pkg::KIND_BAD_MAGIC;
					push_op.last      = 1'b1;
					phase_n           = PH_DONE;
				end else begin
					trunc_chk = 1'b1;
					if (hidx_q == 4'(bfb_pkg::MAGIC_LEN - 1)) begin
						hidx_n  = '0;
						phase_n = PH_KEY;
					end else begin
						hidx_n = hidx_q + 4'd1;
					end
				end
			end
			PH_KEY: begin
				hidx_n    = {3'b000, b == bfb_pkg::PAYLOAD_KEY};
				phase_n   = PH_ZERO;
				trunc_chk = 1'b1;
			end
			PH_ZERO: begin
				if (b != 8'h00) begin
					push_v            = 1'b1;
					push_op.is_result = 1'b1;
					push_op.kind      = bfb_pkg::KIND_MISMATCH;
					push_op.last      = 1'b1;
					phase_n           = PH_DONE;
				end else begin
					trunc_chk = 1'b1;
					if (hidx_q != 4'd0) begin
						hidx_n  = '0;
						size_n  = '0;
						phase_n = PH_SIZE;
					end else begin
						phase_n = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				sec_n     = b;
				phase_n   = (b != 8'h00) ? PH_DATA : PH_KEY;
				trunc_chk = 1'b1;
			end
			PH_DATA: begin
				sec_n     = sec_dec;
				trunc_chk = 1'b1;
				if (sec_dec == 8'h00) begin
					phase_n = PH_KEY;
				end
			end
			PH_SIZE: begin
				size_n = {size_q[15:0], b};
				if (hidx_q == 4'd2) begin
					hidx_n   = '0;
					size_sum = {1'b0, size_n} + 25'd3;
					rem_n    = size_sum[24:2];
					biw_n    = '0;
					if (size_sum[24:2] == 23'd0) begin
						// Empty payload: one word result with nothing in it.
						push_v            = 1'b1;
						push_op.is_result = 1'b1;
						push_op.kind      = bfb_pkg::KIND_WORD;
						push_op.last      = 1'b1;
						phase_n           = PH_DONE;
					end else begin
						trunc_chk = 1'b1;
						phase_n   = PH_PAYLOAD;
					end
				end else begin
					hidx_n    = hidx_q + 4'd1;
					trunc_chk = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				push_v       = 1'b1;
				push_op.data = b;
				push_op.kind = bfb_pkg::KIND_WORD;
				push_op.count = count;
				if (count == 3'd4) begin
					rem_n         = rem_q - 23'd1;
					biw_n         = '0;
					push_op.emit  = 1'b1;
					push_op.last  = (rem_q == 23'd1) || fl;
					if ((rem_q == 23'd1) || fl) begin
						phase_n = PH_DONE;
					end
				end else if (fl) begin
					biw_n        = '0;
					push_op.emit = 1'b1;
					push_op.last = 1'b1;
					phase_n      = PH_DONE;
				end else begin
					biw_n = count[1:0];
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		// End of file anywhere before the payload.
		if (trunc_chk && fl) begin
			push_v            = 1'b1;
			push_op           = '0;
			push_op.is_result = 1'b1;
			push_op.kind      = bfb_pkg::KIND_TRUNCATED;
			push_op.last      = 1'b1;
			phase_n           = PH_DONE;
		end
	end

	// Parser state, updated on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			hidx_q  <= '0;
			sec_q   <= '0;
			size_q  <= '0;
			rem_q   <= '0;
			biw_q   <= '0;
		end else if (beat) begin
			phase_q <= phase_n;
			hidx_q  <= hidx_n;
			sec_q   <= sec_n;
			size_q  <= size_n;
			rem_q   <= rem_n;
			biw_q   <= biw_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/bfb_queue.sv
// Short first-in first-out queue of parser entries between front and back.
// Depends on bfb_pkg.
`default_nettype none

module bfb_queue #(
	parameter int unsigned DEPTH = bfb_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bfb_pkg::op_t  push_op,
	output logic               full,
	input  wire logic          pop,
	output bfb_pkg::op_t       pop_op,
	output logic               empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	bfb_pkg::op_t  mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_op  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/bfb_back.sv
// Back end of the converter: packs payload bytes into words and holds the
// result register. Depends on bfb_pkg, bfb_out_if.
`default_nettype none

module bfb_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_empty,
	input  wire bfb_pkg::op_t  q_op,
	output logic               pop,
	bfb_out_if.source          result
);

	logic          valid_q;
	bfb_pkg::kind_t kind_q;
	logic [31:0]   word_q;
	logic [2:0]    bv_q;
	logic          last_q;
	logic [23:0]   held_q;
	logic [31:0]   acc;
	logic          can_take;

	// The result register may be refilled when empty or being taken.
	assign can_take = !valid_q || result.ready;
	assign pop      = !q_empty && can_take;
	assign acc      = {held_q, q_op.data};

	assign result.valid       = valid_q;
	assign result.kind        = kind_q;
	assign result.word        = word_q;
	assign result.bytes_valid = bv_q;
	assign result.last        = last_q;

	// Result valid flag and partial word; newest byte enters at bits 7:0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			held_q  <= '0;
		end else begin
			if (result.ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				if (q_op.is_result || q_op.emit) begin
					valid_q <= 1'b1;
					held_q  <= '0;
				end else begin
					held_q <= acc[23:0];
				end
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_op.is_result) begin
				kind_q <= q_op.kind;
				word_q <= '0;
				bv_q   <= '0;
				last_q <= 1'b1;
			end else if (q_op.emit) begin
				kind_q <= bfb_pkg::KIND_WORD;
				word_q <= acc;
				bv_q   <= q_op.count;
				last_q <= q_op.last;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/bit_file_to_bin_converter_core.sv
// Top level of the bit-file to bin converter: parser front, entry queue, word back.
// Depends on bfb_pkg, bfb_in_if, bfb_out_if, bfb_front, bfb_queue, bfb_back.
//
// Channel  Modport  Beat carries
// stream   sink     data_byte[7:0], file_last
// result   source   kind[1:0], word[31:0], bytes_valid[2:0], last
//
// One byte is taken per cycle while the queue has room; the result a byte causes is
// registered first as a queue entry, then in the result register.
// The queue (QUEUE_DEPTH entries) lets the parser keep taking bytes while the result
// side stalls; when it fills, stream.ready drops.
// arst_n returns the parser to the magic header check and empties the queue.
// After the final result every byte is taken and dropped until reset.
`default_nettype none

module bit_file_to_bin_converter_core #(
	parameter int unsigned QUEUE_DEPTH = bfb_pkg::QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bfb_in_if.sink     stream,
	bfb_out_if.source  result
);

	logic         push, q_full, pop, q_empty;
	bfb_pkg::op_t push_op, pop_op;

	bfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.q_full  (q_full),
		.push    (push),
		.push_op (push_op)
	);

	bfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.pop_op  (pop_op),
		.empty   (q_empty)
	);

	bfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_op    (pop_op),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_bit_file_to_bin_converter_core.sv
// Self-checking testbench for the bit-file to bin converter core.
// Feeds one synthetic bit file through the stream channel and checks every result beat.
// Depends on bfb_pkg, bfb_in_if, bfb_out_if and bit_file_to_bin_converter_core.
`default_nettype none

module tb_bit_file_to_bin_converter_core;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 20;

	// Parser position within the file.
	typedef enum logic [2:0] {
		ST_MAGIC, ST_KEY, ST_ZERO, ST_LEN, ST_DATA, ST_SIZE, ST_PAYLOAD, ST_DONE
	} parse_t;

	// How the random part of the file ends.
	typedef enum {
		END_FULL, END_CUT, END_EMPTY, END_MISMATCH, END_TRUNC_SECTION, END_TRUNC_SIZE
	} ending_t;

	// How a directed row is checked: typed in as silent, or by the converter model.
	typedef enum logic {CHK_NONE, CHK_MODEL} chk_t;

	typedef struct packed {
		bfb_pkg::kind_t kind;
		logic [31:0]    word;
		logic [2:0]     bytes_valid;
		logic           last;
	} conv_res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fl;
	} file_beat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       fl;
		chk_t       chk;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	bfb_in_if  stream_if ();
	bfb_out_if result_if ();

	bit_file_to_bin_converter_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	always #5 clk = ~clk;

	// Magic header that every bit file starts with.
	logic [7:0] hdr_bytes [0:12] = '{8'h00, 8'h09, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F,
		8'hF0, 8'h0F, 8'hF0, 8'h00, 8'h00, 8'h01};

	// Directed rows: the magic header, then sections with extreme keys and short lengths,
	// including a data byte that looks like the payload key.
	dir_row_t dir_rows [0:24] = '{
		'{8'h00, 1'b0, CHK_NONE}, '{8'h09, 1'b0, CHK_NONE}, '{8'h0F, 1'b0, CHK_NONE},
		'{8'hF0, 1'b0, CHK_NONE}, '{8'h0F, 1'b0, CHK_NONE}, '{8'hF0, 1'b0, CHK_NONE},
		'{8'h0F, 1'b0, CHK_NONE}, '{8'hF0, 1'b0, CHK_NONE}, '{8'h0F, 1'b0, CHK_NONE},
		'{8'hF0, 1'b0, CHK_NONE}, '{8'h00, 1'b0, CHK_NONE}, '{8'h00, 1'b0, CHK_NONE},
		'{8'h01, 1'b0, CHK_NONE},
		'{8'h00, 1'b0, CHK_MODEL}, '{8'h00, 1'b0, CHK_MODEL}, '{8'h01, 1'b0, CHK_MODEL},
		'{8'h65, 1'b0, CHK_MODEL},
		'{8'hFF, 1'b0, CHK_MODEL}, '{8'h00, 1'b0, CHK_MODEL}, '{8'h02, 1'b0, CHK_MODEL},
		'{8'hFF, 1'b0, CHK_MODEL}, '{8'h00, 1'b0, CHK_MODEL},
		'{8'h61, 1'b0, CHK_MODEL}, '{8'h00, 1'b0, CHK_MODEL}, '{8'h00, 1'b0, CHK_MODEL}
	};

	// Converter model state.
	parse_t      pstate;
	logic [3:0]  hdr_pos;
	logic [7:0]  sect_left;
	logic [23:0] size_acc;
	logic [23:0] words_left;
	logic [23:0] part_word;
	logic [1:0]  part_count;

	conv_res_t   expect_q [$];
	file_beat_t  file_q [$];
	ending_t     ending;
	bit          calm;
	int unsigned faults;
	int unsigned results_seen;
	int unsigned words_seen;
	int unsigned bytes_taken;
	int unsigned cycles;

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= 10)
			$display("%s", msg);
	endfunction

	// Advances the converter model by one byte and gives the result it causes, if any.
	task automatic convert_byte(input logic [7:0] b, input logic fl, output logic got,
		output conv_res_t r);
		logic [31:0] acc;
		logic [2:0]  cnt;
		logic        settled;
		logic        last_word;
		got = 1'b0;
		settled = 1'b0;
		r = '{bfb_pkg::KIND_WORD, 32'd0, 3'd0, 1'b0};
		case (pstate)
			ST_MAGIC: begin
				if (hdr_pos >= bfb_pkg::MAGIC_LEN || b != hdr_bytes[hdr_pos]) begin
					r.kind = bfb_pkg::KIND_BAD_MAGIC;
					settled = 1'b1;
				end else begin
					hdr_pos++;
					if (hdr_pos == bfb_pkg::MAGIC_LEN) begin
						hdr_pos = 4'd0;
						pstate = ST_KEY;
					end
				end
			end
			ST_KEY: begin
				hdr_pos = (b == bfb_pkg::PAYLOAD_KEY) ? 4'd1 : 4'd0;
				pstate = ST_ZERO;
			end
			ST_ZERO: begin
				if (b != 8'h00) begin
					r.kind = bfb_pkg::KIND_MISMATCH;
					settled = 1'b1;
				end else if (hdr_pos != 4'd0) begin
					hdr_pos = 4'd0;
					size_acc = 24'd0;
					pstate = ST_SIZE;
				end else begin
					pstate = ST_LEN;
				end
			end
			ST_LEN: begin
				sect_left = b;
				pstate = (b != 8'h00) ? ST_DATA : ST_KEY;
			end
			ST_DATA: begin
				sect_left--;
				if (sect_left == 8'd0)
					pstate = ST_KEY;
			end
			ST_SIZE: begin
				size_acc = {size_acc[15:0], b};
				hdr_pos++;
				if (hdr_pos >= 4'd3) begin
					hdr_pos = 4'd0;
					words_left = 24'((32'(size_acc) + 32'd3) >> 2);
					part_word = 24'd0;
					part_count = 2'd0;
					if (words_left == 24'd0) begin
						// An empty payload closes the file with a bare final beat.
						r.last = 1'b1;
						got = 1'b1;
						settled = 1'b1;
						pstate = ST_DONE;
					end else begin
						pstate = ST_PAYLOAD;
					end
				end
			end
			ST_PAYLOAD: begin
				settled = 1'b1;
				acc = {part_word, b};
				cnt = {1'b0, part_count} + 3'd1;
				if (cnt == 3'd4) begin
					words_left--;
					last_word = (words_left == 24'd0) || fl;
					part_word = 24'd0;
					part_count = 2'd0;
					if (last_word)
						pstate = ST_DONE;
					r = '{bfb_pkg::KIND_WORD, acc, 3'd4, last_word};
					got = 1'b1;
				end else if (fl) begin
					// The file stops inside a word: hand over what has arrived.
					part_word = 24'd0;
					part_count = 2'd0;
					pstate = ST_DONE;
					r = '{bfb_pkg::KIND_WORD, acc, cnt, 1'b1};
					got = 1'b1;
				end else begin
					part_word = acc[23:0];
					part_count = cnt[1:0];
				end
			end
			default: begin
				settled = 1'b1;
			end
		endcase
		// Errors close the file; so does an end of file before the payload.
		if (settled && r.kind != bfb_pkg::KIND_WORD) begin
			r.last = 1'b1;
			got = 1'b1;
			pstate = ST_DONE;
		end else if (!settled && fl) begin
			r = '{bfb_pkg::KIND_TRUNCATED, 32'd0, 3'd0, 1'b1};
			got = 1'b1;
			pstate = ST_DONE;
		end
	endtask

	// Offers one byte on the stream channel, waits for its beat and books its result.
	task automatic send_byte(input logic [7:0] b, input logic fl, input chk_t chk);
		int unsigned gap;
		logic        got;
		conv_res_t   r;
		gap = 0;
		if (!calm && $urandom_range(0, 11) == 0)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			@(negedge clk);
			stream_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		stream_if.valid     <= 1'b1;
		stream_if.data_byte <= b;
		stream_if.file_last <= fl;
		do @(posedge clk); while (stream_if.ready !== 1'b1);
		bytes_taken++;
		convert_byte(b, fl, got, r);
		if (got && chk == CHK_MODEL)
			expect_q.push_back(r);
	endtask

	task automatic put(input logic [7:0] d, input logic fl);
		file_q.push_back('{d, fl});
	endtask

	// Appends whole sections with random keys other than the payload key.
	task automatic add_sections(input int unsigned budget);
		int unsigned start_len;
		int unsigned len;
		logic [7:0]  key;
		start_len = file_q.size();
		while (file_q.size() - start_len < budget) begin
			key = 8'($urandom_range(0, 255));
			if (key == bfb_pkg::PAYLOAD_KEY)
				key = ~bfb_pkg::PAYLOAD_KEY;
			case ($urandom_range(0, 19))
				0:       len = 0;
				1:       len = 255;
				default: len = $urandom_range(1, 40);
			endcase
			put(key, 1'b0);
			put(8'h00, 1'b0);
			put(8'(len), 1'b0);
			repeat (len) put(8'($urandom_range(0, 255)), 1'b0);
		end
	endtask

	task automatic add_size(input logic [23:0] s);
		put(bfb_pkg::PAYLOAD_KEY, 1'b0);
		put(8'h00, 1'b0);
		put(s[23:16], 1'b0);
		put(s[15:8], 1'b0);
		put(s[7:0], 1'b0);
	endtask

	// Builds the random part of the file: sections, then one way of ending it.
	task automatic build_file();
		int unsigned pick;
		int unsigned nbytes;
		int unsigned cut;
		logic [23:0] s;
		logic [7:0]  key;
		pick = $urandom_range(0, 99);
		if (pick < 45)      ending = END_FULL;
		else if (pick < 75) ending = END_CUT;
		else if (pick < 81) ending = END_EMPTY;
		else if (pick < 87) ending = END_MISMATCH;
		else if (pick < 95) ending = END_TRUNC_SECTION;
		else                ending = END_TRUNC_SIZE;
		if (ending == END_FULL || ending == END_CUT)
			add_sections($urandom_range(60, 200));
		else
			add_sections($urandom_range(1700, 1800));
		case (ending)
			END_FULL: begin
				s = 24'($urandom_range(1300, 1700));
				add_size(s);
				nbytes = ((s + 3) / 4) * 4;
				repeat (nbytes - 1) put(8'($urandom_range(0, 255)), 1'b0);
				put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			END_CUT: begin
				// A huge declared size, so the file ends long before the payload does.
				s = {8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535))};
				if ($urandom_range(0, 3) == 0)
					s[23:16] = 8'hFF;
				add_size(s);
				nbytes = $urandom_range(1400, 1700);
				repeat (nbytes - 1) put(8'($urandom_range(0, 255)), 1'b0);
				put(8'($urandom_range(0, 255)), 1'b1);
			end
			END_EMPTY: begin
				add_size(24'd0);
			end
			END_MISMATCH: begin
				key = ($urandom_range(0, 1) != 0) ? bfb_pkg::PAYLOAD_KEY :
					8'($urandom_range(0, 255));
				put(key, 1'b0);
				put(8'($urandom_range(1, 255)), 1'b0);
			end
			END_TRUNC_SECTION: begin
				cut = $urandom_range(1, 60);
				repeat (cut) void'(file_q.pop_back());
				file_q[file_q.size() - 1].fl = 1'b1;
			end
			default: begin
				// End of file somewhere in the three size bytes.
				put(bfb_pkg::PAYLOAD_KEY, 1'b0);
				put(8'h00, 1'b0);
				cut = $urandom_range(0, 2);
				for (int k = 0; k <= cut; k++)
					put(8'($urandom_range(0, 255)), (k == cut) ? 1'b1 : 1'b0);
			end
		endcase
		// Bytes after the final result must be swallowed without a result.
		repeat (20) put(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	// Result side: random stalls, none in the quiet tail of the run.
	initial begin
		result_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 19) == 0) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			result_if.ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest booked result.
	always @(posedge clk) begin
		conv_res_t want;
		if (arst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
			results_seen++;
			if (expect_q.size() == 0) begin
				note_fault($sformatf("Unexpected result: kind=%0d word=%h valid=%0d last=%0d",
					result_if.kind, result_if.word, result_if.bytes_valid, result_if.last));
			end else begin
				want = expect_q.pop_front();
				if (result_if.kind !== want.kind || result_if.word !== want.word ||
					result_if.bytes_valid !== want.bytes_valid ||
					result_if.last !== want.last) begin
					note_fault($sformatf({"Result %0d: expected kind=%0d word=%h valid=%0d ",
						"last=%0d, got kind=%0d word=%h valid=%0d last=%0d"}, results_seen,
						want.kind, want.word, want.bytes_valid, want.last, result_if.kind,
						result_if.word, result_if.bytes_valid, result_if.last));
				end else if (want.kind == bfb_pkg::KIND_WORD && want.bytes_valid == 3'd4) begin
					words_seen++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, expect_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Stimulus and final verdict.
	initial begin
		int unsigned quiet_from;
		int unsigned hold_at;
		faults = 0;
		results_seen = 0;
		words_seen = 0;
		bytes_taken = 0;
		cycles = 0;
		calm = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.data_byte = 8'h00;
		stream_if.file_last = 1'b0;
		pstate = ST_MAGIC;
		hdr_pos = 4'd0;
		sect_left = 8'd0;
		size_acc = 24'd0;
		words_left = 24'd0;
		part_word = 24'd0;
		part_count = 2'd0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_byte(dir_rows[i].data, dir_rows[i].fl, dir_rows[i].chk);

		build_file();
		quiet_from = file_q.size() - file_q.size() / 10;
		hold_at = file_q.size() / 2;
		for (int i = 0; i < file_q.size(); i++) begin
			calm = (i >= quiet_from);
			// Once mid-file the sender stops until every booked result is out.
			if (i == hold_at) begin
				@(negedge clk);
				stream_if.valid <= 1'b0;
				while (expect_q.size() != 0) @(posedge clk);
			end
			send_byte(file_q[i].data, file_q[i].fl, CHK_MODEL);
		end
		@(negedge clk);
		stream_if.valid <= 1'b0;

		while (expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expect_q.size() != 0)
			note_fault($sformatf("%0d results never arrived", expect_q.size()));

		$display("Fed %0d bytes: magic header, sections and a file ending as %s.",
			bytes_taken, ending.name());
		$display("Checked %0d result beats, %0d of them full payload words, %0d faults.",
			results_seen, words_seen, faults);
		if (faults == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/bfb_pkg.sv
rtl/bfb_in_if.sv
rtl/bfb_out_if.sv
rtl/bfb_front.sv
rtl/bfb_queue.sv
rtl/bfb_back.sv
rtl/bit_file_to_bin_converter_core.sv
tb/sv/tb_bit_file_to_bin_converter_core.sv
